[hw/rtl/bfsp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsp_pkg
// Shared constants, types and sequencer states for the shortest-path block.
// ----------------------------------------------------------------------------
package bfsp_pkg;

  localparam int MaxNodes  = 1024;
  localparam int MaxEdges  = 4096;
  localparam int CostWidth = 32;
  localparam int DistWidth = 48;
  localparam int NodeW     = $clog2(MaxNodes);
  localparam int EdgeW     = $clog2(MaxEdges);

  localparam logic [1:0] OpLoad = 2'd0;
  localparam logic [1:0] OpRun  = 2'd1;
  localparam logic [1:0] OpRead = 2'd2;

  localparam logic CfgNodeCount = 1'b0;
  localparam logic CfgEdgeCount = 1'b1;

  typedef struct packed {
    logic [NodeW-1:0]          tail;
    logic [NodeW-1:0]          head;
    logic signed [CostWidth-1:0] cost;
  } edge_t;

  typedef struct packed {
    logic                        reach;
    logic                        pvalid;
    logic [NodeW-1:0]            pred;
    logic signed [DistWidth-1:0] distance;
  } node_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_RESP,
    S_CLR,
    S_EDGE,
    S_TAIL,
    S_HEAD,
    S_RELAX
  } state_e;

endpackage

[hw/rtl/bellman_ford_shortest_paths.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bellman_ford_shortest_paths
// Single-source shortest paths over a stored edge list, one edge at a time.
// ----------------------------------------------------------------------------
// A load is answered from S_RESP, a read from S_RD then S_RESP. The next
// transaction is taken back in S_IDLE, which S_RESP leaves only while the
// output is free. A run first sweeps the node store, then relaxes edges
// through one shared saturating adder and comparator; an edge with endpoints
// in range and a reachable tail passes S_EDGE, S_TAIL, S_HEAD and S_RELAX,
// with an unreachable tail it ends at S_HEAD, and a skipped edge at S_TAIL;
// each pass ends in one more S_EDGE; at most node_count passes, and a found
// negative cycle adds one more sweep. After reset the node store is swept
// once before any item is taken. Configuration writes are taken at any time.
module bellman_ford_shortest_paths (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [11:0] edge_index, [21:12] from_node, [31:22] to_node,
  // [63:32] edge_cost, [73:64] node_select, [79:74] zero
  input  logic [79:0] s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] negative_cycle, [1] reachable, [49:2] node_distance,
  // [50] has_predecessor, [60:51] predecessor_node, [63:61] zero
  output logic [63:0] m_axis_tdata
);

  localparam int NW = bfsp_pkg::NodeW;
  localparam int EW = bfsp_pkg::EdgeW;
  localparam int DW = bfsp_pkg::DistWidth;
  localparam int CW = bfsp_pkg::CostWidth;

  bfsp_pkg::state_e state_q, state_d;

  logic [10:0] node_count_q;
  logic [12:0] edge_count_q;
  logic [10:0] n_eff;
  logic [12:0] m_eff;

  logic [NW-1:0] clr_q, clr_d;
  logic [NW-1:0] src_q, src_d;
  logic          boot_q, boot_d;
  logic          recl_q, recl_d;
  logic [12:0]   j_q, j_d;
  logic [10:0]   pass_q, pass_d;
  logic          check_q, check_d;
  logic          any_q, any_d;
  logic          flag_q, flag_d;
  logic [NW-1:0] a_q, a_d, b_q, b_d;
  logic signed [CW-1:0] w_q, w_d;
  logic signed [DW-1:0] s_q, s_d;

  logic          res_reach_q, res_reach_d, res_hasp_q, res_hasp_d;
  logic [DW-1:0] res_dist_q, res_dist_d;
  logic [NW-1:0] res_pred_q, res_pred_d;

  logic          out_valid_q, out_valid_d;
  logic [63:0]   out_data_q, out_data_d;

  logic            e_we;
  bfsp_pkg::edge_t e_wdata, e_rdata;
  logic            n_we;
  logic [NW-1:0]   n_waddr, n_raddr;
  bfsp_pkg::node_t n_wdata, n_rdata;

  logic       in_fire;
  logic [DW:0] sum;
  logic signed [DW-1:0] sat;

  assign n_eff = (node_count_q > 11'(bfsp_pkg::MaxNodes)) ? 11'(bfsp_pkg::MaxNodes)
                                                           : node_count_q;
  assign m_eff = (edge_count_q > 13'(bfsp_pkg::MaxEdges)) ? 13'(bfsp_pkg::MaxEdges)
                                                           : edge_count_q;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == bfsp_pkg::S_IDLE);

  assign e_we    = in_fire && (s_axis_tuser == bfsp_pkg::OpLoad);
  assign e_wdata = '{tail: s_axis_tdata[21:12], head: s_axis_tdata[31:22],
                     cost: s_axis_tdata[63:32]};

  bfsp_ram #(.Width($bits(bfsp_pkg::edge_t)), .Depth(bfsp_pkg::MaxEdges)) u_edges (
    .clk_i  (clk_i),
    .we_i   (e_we),
    .waddr_i(s_axis_tdata[EW-1:0]),
    .wdata_i(e_wdata),
    .raddr_i(j_q[EW-1:0]),
    .rdata_o(e_rdata)
  );

  bfsp_ram #(.Width($bits(bfsp_pkg::node_t)), .Depth(bfsp_pkg::MaxNodes)) u_nodes (
    .clk_i  (clk_i),
    .we_i   (n_we),
    .waddr_i(n_waddr),
    .wdata_i(n_wdata),
    .raddr_i(n_raddr),
    .rdata_o(n_rdata)
  );

  // saturate tail distance plus cost to the distance range
  assign sum = {n_rdata.distance[DW-1], n_rdata.distance} + (DW+1)'(signed'(w_q));
  always_comb begin
    if (sum[DW] != sum[DW-1]) begin
      sat = sum[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      sat = sum[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= 11'd1;
      edge_count_q <= 13'd0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == bfsp_pkg::CfgNodeCount) begin
        node_count_q <= cfg_data_i[10:0];
      end else begin
        edge_count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfsp_pkg::S_CLR;
      clr_q       <= '0;
      boot_q      <= 1'b1;
      recl_q      <= 1'b0;
      j_q         <= '0;
      pass_q      <= '0;
      check_q     <= 1'b0;
      any_q       <= 1'b0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      boot_q      <= boot_d;
      recl_q      <= recl_d;
      j_q         <= j_d;
      pass_q      <= pass_d;
      check_q     <= check_d;
      any_q       <= any_d;
      flag_q      <= flag_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q       <= src_d;
    a_q         <= a_d;
    b_q         <= b_d;
    w_q         <= w_d;
    s_q         <= s_d;
    res_reach_q <= res_reach_d;
    res_hasp_q  <= res_hasp_d;
    res_dist_q  <= res_dist_d;
    res_pred_q  <= res_pred_d;
    out_data_q  <= out_data_d;
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    src_d       = src_q;
    boot_d      = boot_q;
    recl_d      = recl_q;
    j_d         = j_q;
    pass_d      = pass_q;
    check_d     = check_q;
    any_d       = any_q;
    flag_d      = flag_q;
    a_d         = a_q;
    b_d         = b_q;
    w_d         = w_q;
    s_d         = s_q;
    res_reach_d = res_reach_q;
    res_hasp_d  = res_hasp_q;
    res_dist_d  = res_dist_q;
    res_pred_d  = res_pred_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    n_we        = 1'b0;
    n_waddr     = clr_q;
    n_wdata     = '0;
    n_raddr     = b_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      bfsp_pkg::S_IDLE: begin
        n_raddr     = s_axis_tdata[73:64];
        res_reach_d = 1'b0;
        res_hasp_d  = 1'b0;
        res_dist_d  = '0;
        res_pred_d  = '0;
        if (in_fire) begin
          case (s_axis_tuser)
            bfsp_pkg::OpRead: state_d = bfsp_pkg::S_RD;
            bfsp_pkg::OpRun: begin
              src_d   = s_axis_tdata[73:64];
              flag_d  = 1'b0;
              clr_d   = '0;
              recl_d  = 1'b0;
              state_d = bfsp_pkg::S_CLR;
            end
            default: state_d = bfsp_pkg::S_RESP;
          endcase
        end
      end
      bfsp_pkg::S_RD: begin
        res_reach_d = n_rdata.reach;
        res_dist_d  = n_rdata.reach ? n_rdata.distance : '0;
        res_hasp_d  = n_rdata.pvalid;
        res_pred_d  = n_rdata.pvalid ? n_rdata.pred : '0;
        state_d     = bfsp_pkg::S_RESP;
      end
      bfsp_pkg::S_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {3'b000, res_pred_q, res_hasp_q, res_dist_q, res_reach_q, flag_q};
          state_d     = bfsp_pkg::S_IDLE;
        end
      end
      bfsp_pkg::S_CLR: begin
        n_we          = 1'b1;
        n_wdata.reach = !boot_q && ({1'b0, src_q} < n_eff) && (clr_q == src_q);
        clr_d         = clr_q + 1'b1;
        if (clr_q == NW'(bfsp_pkg::MaxNodes - 1)) begin
          j_d     = '0;
          pass_d  = '0;
          any_d   = 1'b0;
          check_d = (n_eff == 11'd1);
          if (boot_q) begin
            boot_d  = 1'b0;
            state_d = bfsp_pkg::S_IDLE;
          end else if (recl_q || n_eff == 11'd0) begin
            state_d = bfsp_pkg::S_RESP;
          end else begin
            state_d = bfsp_pkg::S_EDGE;
          end
        end
      end
      bfsp_pkg::S_EDGE: begin
        if (j_q == m_eff) begin
          j_d   = '0;
          any_d = 1'b0;
          // end of pass: stop early, move to the cycle check, or go again
          if (check_q || !any_q) begin
            state_d = bfsp_pkg::S_RESP;
          end else begin
            pass_d = pass_q + 1'b1;
            if (pass_q + 11'd1 == n_eff - 11'd1) begin
              check_d = 1'b1;
            end
          end
        end else begin
          state_d = bfsp_pkg::S_TAIL;
        end
      end
      bfsp_pkg::S_TAIL: begin
        a_d     = e_rdata.tail;
        b_d     = e_rdata.head;
        w_d     = e_rdata.cost;
        n_raddr = e_rdata.tail;
        if (({1'b0, e_rdata.tail} >= n_eff) || ({1'b0, e_rdata.head} >= n_eff)) begin
          j_d     = j_q + 1'b1;
          state_d = bfsp_pkg::S_EDGE;
        end else begin
          state_d = bfsp_pkg::S_HEAD;
        end
      end
      bfsp_pkg::S_HEAD: begin
        s_d = sat;
        if (!n_rdata.reach) begin
          j_d     = j_q + 1'b1;
          state_d = bfsp_pkg::S_EDGE;
        end else begin
          state_d = bfsp_pkg::S_RELAX;
        end
      end
      bfsp_pkg::S_RELAX: begin
        j_d     = j_q + 1'b1;
        state_d = bfsp_pkg::S_EDGE;
        if (!n_rdata.reach || (s_q < n_rdata.distance)) begin
          if (check_q) begin
            flag_d  = 1'b1;
            recl_d  = 1'b1;
            clr_d   = '0;
            state_d = bfsp_pkg::S_CLR;
          end else begin
            n_we    = 1'b1;
            n_waddr = b_q;
            n_wdata = '{reach: 1'b1, pvalid: 1'b1, pred: a_q, distance: s_q};
            any_d   = 1'b1;
          end
        end
      end
      default: state_d = bfsp_pkg::S_IDLE;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_relax_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bfsp_pkg::S_RELAX) |-> ({1'b0, b_q} < n_eff))
    else $error("relaxing an edge whose head is out of range");

  a_head_after_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bfsp_pkg::S_HEAD) |-> ($past(state_q) == bfsp_pkg::S_TAIL))
    else $error("head lookup without a tail lookup");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bfsp_pkg::S_RESP && out_valid_q && !m_axis_tready)
      |=> (state_q == bfsp_pkg::S_RESP))
    else $error("result dropped while output is stalled");

endmodule

[hw/rtl/bfsp_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsp_ram
// Single write port, single registered read port RAM.
// ----------------------------------------------------------------------------
module bfsp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
